// ===== hdl/deq_pkg.sv =====
package deq_pkg;

  // Default number of entries in the ring buffer.
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_LIST_ALL   = 3'd4
  } deq_mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_LIST
  } deq_state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } deq_in_req_t;

  typedef struct packed {
    deq_status_t        status;
    logic signed [31:0] value_res;
    logic               last;
  } deq_out_res_t;

endpackage

// ===== hdl/deq_ram.sv =====
module deq_ram #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  import deq_pkg::*;

  // Single write port, single registered read port.
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// Double-ended queue of signed 32-bit values held in a ring buffer.
// Requests enter on in_req and are accepted at a rising edge where start is
// high and busy is low. A request carries a mode (push front, push back, pop
// front, pop back or list all) and a value that only the pushes use.
// Undefined modes are accepted and dropped without a result.
//
// Results leave on out_res, each valid for exactly one cycle while out_valid
// is high. The receiver cannot stall the block, so every result must be taken
// in the cycle it appears. Each request with a defined mode ends with a result that has last set.
//
// Timing: a push, or any request that fails on an empty or full queue, shows
// its result in the cycle after acceptance and busy stays low, so such
// requests can follow every cycle. A successful pop issues a read of the
// storage memory at acceptance; the data passes through the memory's read
// register and then the result register, and busy is high for one cycle. A
// list streams one element per cycle along the same path, with busy high
// while the list is in progress. The registered memory read port sets this.
//
// Reset (rst_n low, synchronous) empties the queue and clears the front
// pointer; the storage memory itself is not cleared.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  deq_pkg::deq_in_req_t  in_req,
  output logic                  out_valid,
  output deq_pkg::deq_out_res_t out_res
);
  import deq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Control and pointer state.
  deq_state_t   state_r, state_nxt;
  logic [PW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          out_valid_r, out_valid_nxt;
  deq_out_res_t  out_res_r, out_res_nxt;

  // Storage memory port signals.
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [PW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic accept;
  logic full;
  logic empty;

  // Index arithmetic modulo DEPTH. Both operands stay below DEPTH, so a single
  // compare and subtract folds the sum back into range.
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] a);
    return (a == PW'(DEPTH - 1)) ? '0 : a + PW'(1);
  endfunction

  function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] a);
    return (a == '0) ? PW'(DEPTH - 1) : a - PW'(1);
  endfunction

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_req.value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '{status: STAT_OK, value_res: '0, last: 1'b1};
    mem_we        = 1'b0;
    mem_waddr     = front_r;
    mem_raddr     = ptr_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.mode)
            MODE_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_res_nxt.status = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_dec(front_r);
                front_nxt = wrap_dec(front_r);
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_res_nxt.status = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_add(front_r, PW'(count_r));
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = STAT_EMPTY;
              end else begin
                mem_raddr = front_r;
                front_nxt = wrap_inc(front_r);
                count_nxt = count_r - CW'(1);
                state_nxt = ST_POP;
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = STAT_EMPTY;
              end else begin
                mem_raddr = wrap_add(front_r, PW'(count_r - CW'(1)));
                count_nxt = count_r - CW'(1);
                state_nxt = ST_POP;
              end
            end
            MODE_LIST_ALL: begin
              if (empty) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = STAT_EMPTY;
              end else begin
                mem_raddr = front_r;
                ptr_nxt   = wrap_inc(front_r);
                left_nxt  = count_r;
                state_nxt = ST_LIST;
              end
            end
            default: begin
              // Undefined modes are dropped silently.
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt         = 1'b1;
        out_res_nxt.value_res = mem_rdata;
        state_nxt             = ST_IDLE;
      end
      ST_LIST: begin
        // Emit the element read last cycle and fetch the next one.
        out_valid_nxt         = 1'b1;
        out_res_nxt.value_res = mem_rdata;
        out_res_nxt.last      = (left_r == CW'(1));
        mem_raddr             = ptr_r;
        ptr_nxt               = wrap_inc(ptr_r);
        left_nxt              = left_r - CW'(1);
        if (left_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // The element count never exceeds the capacity and the front stays in range.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(DEPTH)) && (front_r <= PW'(DEPTH - 1)))
    else $error("queue count or front pointer out of range");

  // A successful push grows the queue by exactly one element.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full && ((in_req.mode == MODE_PUSH_FRONT) ||
                         (in_req.mode == MODE_PUSH_BACK)))
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the queue by one");

  // The final list result returns the block to idle.
  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST && left_r == CW'(1)) |=> (state_r == ST_IDLE && out_valid))
    else $error("list did not end after its last element");

  // The list walk never outlasts the number of stored elements.
  a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> (left_r != '0 && left_r <= count_r))
    else $error("list remaining count inconsistent");

endmodule
